// File: rtl/core/etg_pkg.sv
package etg_pkg;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic load_num;   // capture the number, restart candidate and count
    logic start_gcd;  // load the gcd operand pair for the current candidate
    logic gcd_step;   // advance the binary gcd by one step
    logic gcd_close;  // fold the gcd outcome into the count, move to next candidate
    logic emit;       // move the finished count into the output register
  } etg_cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic cand_done;  // no candidate left below the number
    logic gcd_end;    // gcd outcome is known this cycle
    logic out_hold;   // output register is full and not being taken
  } etg_sts_t;

endpackage

// File: rtl/core/etg_ctrl.sv
module etg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  etg_pkg::etg_sts_t sts,
  output etg_pkg::etg_cmd_t cmd
);
  import etg_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_CAND   = 4'b0010,
    ST_GCD    = 4'b0100,
    ST_FINISH = 4'b1000
  } etg_state_t;

  etg_state_t state_r;
  etg_state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_num = 1'b1;
          state_nxt    = ST_CAND;
        end
      end
      ST_CAND: begin
        if (sts.cand_done) begin
          state_nxt = ST_FINISH;
        end else begin
          cmd.start_gcd = 1'b1;
          state_nxt     = ST_GCD;
        end
      end
      ST_GCD: begin
        if (sts.gcd_end) begin
          cmd.gcd_close = 1'b1;
          state_nxt     = ST_CAND;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      ST_FINISH: begin
        if (!sts.out_hold) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/core/etg_dp.sv
module etg_dp #(
  parameter int VALUE_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [VALUE_BITS-1:0] in_number,
  input  etg_pkg::etg_cmd_t     cmd,
  output etg_pkg::etg_sts_t     sts,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [VALUE_BITS-1:0] out_coprime_count
);
  import etg_pkg::*;

  localparam logic [VALUE_BITS-1:0] ONE = VALUE_BITS'(1);

  logic [VALUE_BITS-1:0] n_r,   n_nxt;
  logic [VALUE_BITS-1:0] i_r,   i_nxt;
  logic [VALUE_BITS-1:0] a_r,   a_nxt;
  logic [VALUE_BITS-1:0] b_r,   b_nxt;
  logic [VALUE_BITS-1:0] cnt_r, cnt_nxt;
  logic [VALUE_BITS-1:0] out_count_r, out_count_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic                  a_zero;
  logic                  b_zero;
  logic                  both_even;
  logic                  coprime;
  logic                  a_ge_b;
  logic [VALUE_BITS-1:0] diff;

  assign a_zero    = (a_r == '0);
  assign b_zero    = (b_r == '0);
  assign both_even = !a_r[0] && !b_r[0];
  // gcd is 1 when the surviving operand is 1; a shared factor of two ends early
  assign coprime   = (a_zero && (b_r == ONE)) || (b_zero && (a_r == ONE));
  assign a_ge_b    = (a_r >= b_r);
  assign diff      = a_ge_b ? (a_r - b_r) : (b_r - a_r);

  assign sts.cand_done = (i_r >= n_r);
  assign sts.gcd_end   = a_zero || b_zero || both_even;
  assign sts.out_hold  = out_valid_r && !out_ready;

  always_comb begin
    n_nxt         = n_r;
    i_nxt         = i_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    cnt_nxt       = cnt_r;
    out_count_nxt = out_count_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (cmd.load_num) begin
      n_nxt   = in_number;
      i_nxt   = ONE;
      cnt_nxt = '0;
    end
    if (cmd.start_gcd) begin
      a_nxt = i_r;
      b_nxt = n_r;
    end
    if (cmd.gcd_step) begin
      priority if (!a_r[0]) begin
        a_nxt = a_r >> 1;
      end else if (!b_r[0]) begin
        b_nxt = b_r >> 1;
      end else if (a_ge_b) begin
        a_nxt = diff >> 1;
      end else begin
        b_nxt = diff >> 1;
      end
    end
    if (cmd.gcd_close) begin
      i_nxt = i_r + ONE;
      if (coprime) begin
        cnt_nxt = cnt_r + ONE;
      end
    end
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      out_count_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    i_r         <= i_nxt;
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    cnt_r       <= cnt_nxt;
    out_count_r <= out_count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_coprime_count = out_count_r;

endmodule

// File: rtl/core/euler_totient_by_gcd.sv
// Euler totient counter: for each accepted number n it returns how many i in
// 1..n-1 share no factor with n (numbers 0 and 1 give 0). One number is worked
// on at a time. The sequencer walks the candidates i one by one and runs a
// binary gcd on (i, n) in a shared subtract-and-shift unit, one step per
// cycle; a common factor of two ends a test at once. Each candidate has a
// setup step that loads the operands, the gcd steps and a closing step that
// folds the outcome into the count.
// The result sits in an output register; a new number is taken while it waits.
module euler_totient_by_gcd #(
  parameter int VALUE_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VALUE_BITS-1:0] in_number,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [VALUE_BITS-1:0] out_coprime_count
);
  import etg_pkg::*;

  etg_cmd_t cmd;
  etg_sts_t sts;

  // Sequencer: candidate walk, gcd run and result hand-off.
  etg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: number, candidate, gcd operands, count and output register.
  etg_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_number         (in_number),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_coprime_count (out_coprime_count)
  );

  // Hold off new input for the cycle after a transfer: the candidate walk owns it.
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while an item is in progress");

  // The count never reaches all ones: at most n-1 candidates below n.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_coprime_count != {VALUE_BITS{1'b1}}))
    else $error("coprime count out of range");

  // Zero and one have no candidate and return zero via the candidate check and the finish state.
  a_trivial_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !out_valid && (in_number < VALUE_BITS'(2)))
      |-> ##3 (out_valid && (out_coprime_count == '0)))
    else $error("trivial input did not give a zero count");

  // At most one datapath command is raised at a time: a gcd closing and a new operand load never coincide.
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load_num, cmd.start_gcd, cmd.gcd_step, cmd.gcd_close, cmd.emit}))
    else $error("conflicting datapath commands");

endmodule
